// ----- rtl/bmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants of the bracket match checker.
// ----------------------------------------------------------------------------
package bmc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;

   typedef enum logic [2:0] {
      VERDICT_PENDING   = 3'd0,
      VERDICT_MATCHED   = 3'd1,
      VERDICT_WRONGKIND = 3'd2,
      VERDICT_UNMATCHED = 3'd3,
      VERDICT_UNCLOSED  = 3'd4,
      VERDICT_OVERFLOW  = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      OP_OTHER = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   // kind: 0 round, 1 square
   typedef struct packed {
      op_type op;
      logic   kind;
      logic   eos;
   } op_item_type;

endpackage

// ----- rtl/bmc_if.sv -----
// ----------------------------------------------------------------------------
// bmc_req_if / bmc_rsp_if
// Valid/ready channels for characters in and verdicts out.
// ----------------------------------------------------------------------------
interface bmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_string;

   modport source (output valid, output char_in, output end_of_string, input ready);
   modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface bmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;
   logic       string_done;

   modport source (output valid, output verdict, output string_done, input ready);
   modport sink   (input valid, input verdict, input string_done, output ready);
endinterface

// ----- rtl/bmc_ram.sv -----
// ----------------------------------------------------------------------------
// bmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bmc_front.sv -----
// ----------------------------------------------------------------------------
// bmc_front
// Accepts characters and classifies each into open, close or other.
// ----------------------------------------------------------------------------
module bmc_front (
   bmc_req_if.sink             req_chan,
   output logic                wr_valid,
   output bmc_pkg::op_item_type wr_item,
   input  logic                wr_ready
);
   import bmc_pkg::*;

   op_item_type item;

   always_comb begin
      item.eos  = req_chan.end_of_string;
      item.kind = (req_chan.char_in == CHAR_SQUARE_OPEN) ||
                  (req_chan.char_in == CHAR_SQUARE_CLOSE);
      if ((req_chan.char_in == CHAR_ROUND_OPEN) || (req_chan.char_in == CHAR_SQUARE_OPEN)) begin
         item.op = OP_OPEN;
      end else if ((req_chan.char_in == CHAR_ROUND_CLOSE) ||
                   (req_chan.char_in == CHAR_SQUARE_CLOSE)) begin
         item.op = OP_CLOSE;
      end else begin
         item.op = OP_OTHER;
      end
   end

   assign wr_valid       = req_chan.valid;
   assign wr_item        = item;
   assign req_chan.ready = wr_ready;

endmodule

// ----- rtl/bmc_queue.sv -----
// ----------------------------------------------------------------------------
// bmc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bmc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  bmc_pkg::op_item_type wr_item,
   output logic                 wr_ready,
   output logic                 rd_valid,
   output bmc_pkg::op_item_type rd_item,
   input  logic                 rd_take
);
   import bmc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   op_item_type   slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign wr_ready = (count_ff != FULL_COUNT);
   assign rd_valid = (count_ff != '0);
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_take && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/bmc_back.sv -----
// ----------------------------------------------------------------------------
// bmc_back
// Runs the kind stack, latches the first fault and registers each verdict.
// ----------------------------------------------------------------------------
module bmc_back #(
   parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_valid,
   input  bmc_pkg::op_item_type rd_item,
   output logic                 rd_take,
   bmc_rsp_if.source            rsp_chan
);
   import bmc_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);
   localparam logic [DW-1:0] TWO        = DW'(2);

   // top of stack lives in top_ff; the RAM keeps every pushed entry and
   // always presents the entry just below the top
   logic [DW-1:0] depth_ff, depth_in;
   verdict_type   fault_ff, fault_in;
   logic          top_ff, top_in;
   logic          rsp_valid_ff, rsp_valid_in;
   verdict_type   verdict_ff, verdict_in;
   logic          done_ff;
   logic          push;
   logic          below_kind;
   logic [DW-1:0] rd_depth;
   logic [AW-1:0] rd_addr;

   assign rd_take = rd_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      fault_in   = fault_ff;
      depth_in   = depth_ff;
      top_in     = top_ff;
      push       = 1'b0;
      verdict_in = VERDICT_PENDING;
      if (rd_take) begin
         if (fault_ff == VERDICT_PENDING) begin
            unique case (rd_item.op)
               OP_OPEN: begin
                  if (depth_ff == FULL_DEPTH) begin
                     fault_in = VERDICT_OVERFLOW;
                  end else begin
                     push     = 1'b1;
                     depth_in = depth_ff + 1'b1;
                     top_in   = rd_item.kind;
                  end
               end
               OP_CLOSE: begin
                  if (depth_ff == '0) begin
                     fault_in = VERDICT_UNMATCHED;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                     top_in   = below_kind;
                     if (top_ff != rd_item.kind) begin
                        fault_in = VERDICT_WRONGKIND;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (rd_item.eos) begin
            priority if (fault_in != VERDICT_PENDING) begin
               verdict_in = fault_in;
            end else if (depth_in != '0) begin
               verdict_in = VERDICT_UNCLOSED;
            end else begin
               verdict_in = VERDICT_MATCHED;
            end
            depth_in = '0;
            fault_in = VERDICT_PENDING;
         end
      end
   end

   always_comb begin
      rd_depth = (depth_in < TWO) ? '0 : depth_in - TWO;
      rd_addr  = rd_depth[AW-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         fault_ff     <= VERDICT_PENDING;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (rd_take) begin
         verdict_ff <= verdict_in;
         done_ff    <= rd_item.eos;
      end
   end

   bmc_ram #(
      .WIDTH (1),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (rd_item.kind),
      .rd_addr (rd_addr),
      .rd_data (below_kind)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.verdict     = verdict_ff;
   assign rsp_chan.string_done = done_ff;

endmodule

// ----- rtl/bracket_match_checker.sv -----
// ----------------------------------------------------------------------------
// bracket_match_checker
// Checks nesting of round and square brackets, one character per item.
// ----------------------------------------------------------------------------
//   channel   dir  payload                      accepted when
//   req_chan  in   char_in[8], end_of_string    valid && ready
//   rsp_chan  out  verdict[3], string_done      valid && ready
//
// One item per cycle sustained while the output is not stalled; a verdict passes
// a queue slot, then the stack update into the output register, after its character is taken.
// Every stack push or pop is one RAM write or one registered read per cycle.
// Reset clears depth, fault, queue and output valid; stack RAM is not cleared.
// A stalled output holds the back end; the two-slot queue keeps taking items until full.
// ----------------------------------------------------------------------------
module bracket_match_checker #(
   parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bmc_req_if.sink    req_chan,
   bmc_rsp_if.source  rsp_chan
);
   import bmc_pkg::*;

   logic        wr_valid, wr_ready;
   op_item_type wr_item;
   logic        rd_valid, rd_take;
   op_item_type rd_item;

   bmc_front u_front (
      .req_chan (req_chan),
      .wr_valid (wr_valid),
      .wr_item  (wr_item),
      .wr_ready (wr_ready)
   );

   bmc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_item  (wr_item),
      .wr_ready (wr_ready),
      .rd_valid (rd_valid),
      .rd_item  (rd_item),
      .rd_take  (rd_take)
   );

   bmc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_valid (rd_valid),
      .rd_item  (rd_item),
      .rd_take  (rd_take),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- sim/bracket_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// bracket_verdict_checker
// Watches both channels of the bracket match checker, predicts the verdict of
// every accepted character and compares it with the verdict items returned.
// ----------------------------------------------------------------------------
module bracket_verdict_checker #(
   parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   bmc_req_if   req_mon,
   bmc_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   verdicts_owed
);
   import bmc_pkg::*;

   typedef struct packed {
      verdict_type verdict;
      logic        string_done;
   } verdict_rec_type;

   verdict_rec_type owed_verdicts[$];
   logic            nest_kinds [STACK_DEPTH];
   int unsigned     nest_depth;
   verdict_type     first_fault;

   // Advance the nesting state by one character and return its verdict item.
   function automatic verdict_rec_type judge_char(input logic [7:0] c, input logic eos);
      verdict_rec_type rec;
      logic            is_square;
      is_square = (c == CHAR_SQUARE_OPEN) || (c == CHAR_SQUARE_CLOSE);
      if (first_fault == VERDICT_PENDING) begin
         if (c == CHAR_ROUND_OPEN || c == CHAR_SQUARE_OPEN) begin
            if (nest_depth >= STACK_DEPTH) begin
               first_fault = VERDICT_OVERFLOW;
            end else begin
               nest_kinds[nest_depth] = is_square;
               nest_depth++;
            end
         end else if (c == CHAR_ROUND_CLOSE || c == CHAR_SQUARE_CLOSE) begin
            if (nest_depth == 0) begin
               first_fault = VERDICT_UNMATCHED;
            end else begin
               // pop even when the kind is wrong
               nest_depth--;
               if (nest_kinds[nest_depth] != is_square) first_fault = VERDICT_WRONGKIND;
            end
         end
      end
      rec.string_done = eos;
      rec.verdict     = VERDICT_PENDING;
      if (eos) begin
         if (first_fault != VERDICT_PENDING) rec.verdict = first_fault;
         else if (nest_depth != 0)           rec.verdict = VERDICT_UNCLOSED;
         else                                rec.verdict = VERDICT_MATCHED;
         nest_depth  = 0;
         first_fault = VERDICT_PENDING;
      end
      return rec;
   endfunction

   always @(posedge clock) begin
      verdict_rec_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         owed_verdicts.delete();
         nest_depth     = 0;
         first_fault    = VERDICT_PENDING;
         mismatch_count <= 0;
         verdicts_owed  <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            owed_verdicts.push_back(judge_char(req_mon.char_in, req_mon.end_of_string));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_verdicts.size() == 0) begin
               $error("verdict item with none expected: verdict %0d, string_done %0d",
                      rsp_mon.verdict, rsp_mon.string_done);
               errs++;
            end else begin
               want = owed_verdicts.pop_front();
               if (rsp_mon.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, actual %0d", want.verdict, rsp_mon.verdict);
                  errs++;
               end
               if (rsp_mon.string_done !== want.string_done) begin
                  $error("string_done: expected %0d, actual %0d",
                         want.string_done, rsp_mon.string_done);
                  errs++;
               end
            end
         end
         mismatch_count <= mismatch_count + errs;
         verdicts_owed  <= owed_verdicts.size();
      end
   end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives character strings into the bracket match checker: a short directed
// set of strings, then random nested, broken, deep and noise strings under
// three idling phases. Prediction and comparison sit in the verdict checker.
// ----------------------------------------------------------------------------
module tb_top;
   import bmc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 335;

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct;
   int rsp_idle_pct;
   int items_sent;
   int quiet_cycles;
   int mismatch_count;
   int verdicts_owed;

   logic [7:0] line_buf[$];

   bmc_req_if req_chan ();
   bmc_rsp_if rsp_chan ();

   bracket_match_checker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bracket_verdict_checker verdict_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .verdicts_owed  (verdicts_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.char_in       <= c;
      req_chan.end_of_string <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
   endtask

   function automatic logic [7:0] close_of(input logic square);
      return square ? CHAR_SQUARE_CLOSE : CHAR_ROUND_CLOSE;
   endfunction

   function automatic logic [7:0] open_of(input logic square);
      return square ? CHAR_SQUARE_OPEN : CHAR_ROUND_OPEN;
   endfunction

   // Random walk of opens, closes and filler bytes; optionally close what is left.
   task automatic build_nested(input int target_len, input bit close_all);
      logic kinds[$];
      int   roll;
      line_buf.delete();
      for (int n = 0; n < target_len; n++) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            kinds.push_back(1'($urandom_range(1)));
            line_buf.push_back(open_of(kinds[$]));
         end else if (roll < 75 && kinds.size() > 0) begin
            line_buf.push_back(close_of(kinds.pop_back()));
         end else begin
            line_buf.push_back(8'($urandom_range(255)));
         end
      end
      if (close_all) begin
         while (kinds.size() > 0) line_buf.push_back(close_of(kinds.pop_back()));
      end
   endtask

   // Straight run of opens to the given depth, then the matching closes.
   task automatic build_deep(input int depth);
      logic kinds[$];
      line_buf.delete();
      repeat (depth) begin
         kinds.push_back(1'($urandom_range(1)));
         line_buf.push_back(open_of(kinds[$]));
      end
      while (kinds.size() > 0) line_buf.push_back(close_of(kinds.pop_back()));
   endtask

   task automatic build_random_line();
      int mode;
      int spot;
      int closes[$];
      mode = $urandom_range(99);
      if (mode >= 88) begin
         // raw noise
         line_buf.delete();
         repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
      end else begin
         build_nested($urandom_range(1, 24), !(mode >= 60 && mode < 70));
         if (mode >= 70 && mode < 80) begin
            // flip the kind of one close
            for (int i = 0; i < line_buf.size(); i++) begin
               if (line_buf[i] == CHAR_ROUND_CLOSE || line_buf[i] == CHAR_SQUARE_CLOSE)
                  closes.push_back(i);
            end
            if (closes.size() > 0) begin
               spot = closes[$urandom_range(closes.size() - 1)];
               line_buf[spot] = (line_buf[spot] == CHAR_ROUND_CLOSE) ?
                                CHAR_SQUARE_CLOSE : CHAR_ROUND_CLOSE;
            end
         end else if (mode >= 80) begin
            spot = $urandom_range(line_buf.size() - 1);
            line_buf.insert(spot, close_of(1'($urandom_range(1))));
         end
      end
   endtask

   initial begin
      int send_pct [3];
      int recv_pct [3];
      int deep_len [3];
      int phase_start;
      bit deep_done;

      send_pct = '{26, 65, 0};
      recv_pct = '{65, 26, 0};
      deep_len = '{64, 65, 0};
      deep_len[2] = $urandom_range(63, 72);

      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.char_in       = 8'h00;
      req_chan.end_of_string = 1'b0;
      rsp_chan.ready         = 1'b0;
      send_idle_pct          = send_pct[0];
      rsp_idle_pct           = recv_pct[0];
      items_sent             = 0;
      quiet_cycles           = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_string("()");
      send_string("[]");
      send_string("(]");
      send_string("]");
      send_string("[");
      // error latched early, rest of the string ignored
      send_string("[(])])");
      send_string("([])z");
      send_string("(a");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_string(")(");

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pct[phase];
         rsp_idle_pct  = recv_pct[phase];
         phase_start   = items_sent;
         deep_done     = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS || !deep_done) begin
            if (!deep_done && items_sent - phase_start >= PHASE_ITEMS / 3) begin
               build_deep(deep_len[phase]);
               deep_done = 1'b1;
            end else begin
               build_random_line();
            end
            send_line();
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bmc_pkg.sv
rtl/bmc_if.sv
rtl/bmc_ram.sv
rtl/bmc_front.sv
rtl/bmc_queue.sv
rtl/bmc_back.sv
rtl/bracket_match_checker.sv
sim/bracket_verdict_checker.sv
sim/tb_top.sv
